FILE: rtl/mcs_pkg.sv
// shared constants, types and weight table of the motion curve smoother
`default_nettype none
package mcs_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int CHANNELS = 6;
	localparam int FRAME_BITS = SAMPLE_BITS * CHANNELS;
	localparam int HIST_DEPTH = 64;
	localparam int HIST_AW = 6;
	localparam int MAX_WINDOW = 31;
	localparam int WGT_W = 28;
	localparam int TOT_W = 31;
	localparam int ACC_W = 64;
	localparam int BINOM_N = 136;
	localparam int BINOM_AW = 8;
	localparam int MAX_RESULTS = 16;

	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_AVG = 2'd1;
	localparam logic [1:0] MODE_WGT = 2'd2;
	localparam logic [1:0] MODE_BINOM = 2'd3;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef logic [WGT_W-1:0] binom_rom_t [BINOM_N];

	typedef struct packed {
		logic clr;
		logic vld_s1;
		logic rnd;
		logic load;
		logic step;
	} lane_ctrl_t;

	// half rows of pascal's triangle for even orders 0..30
	function automatic binom_rom_t binom_rom();
		binom_rom_t rom;
		logic [WGT_W-1:0] row [MAX_WINDOW];
		int idx;
		idx = 0;
		for (int r = 0; r < MAX_WINDOW; r++) row[r] = '0;
		row[0] = WGT_W'(1);
		for (int n = 0; n < MAX_WINDOW; n++) begin
			for (int r = n; r >= 1; r--) row[r] = row[r] + row[r-1];
			if ((n % 2) == 0) begin
				for (int r = 0; r <= n / 2; r++) begin
					rom[idx] = row[r];
					idx = idx + 1;
				end
			end
		end
		return rom;
	endfunction

	localparam binom_rom_t BINOM = binom_rom();

endpackage
`default_nettype wire

FILE: rtl/motion_curve_smoother.sv
// six-channel motion frame smoother, top level
// usage: frames enter on the s_axis channel (tdata six signed Q16.16 samples,
// tlast marks the last frame of a sequence); smoothed frames leave on m_axis
// with tlast set on the result of the last frame. cfg_index/cfg_data with
// cfg_valid write filter_mode (index 0) and window_size (index 1); cfg_ready
// is always high; the user must make writes while the block is idle (unenforced).
// a frame is taken only while the sequencer is idle. each result is built by
// six channel lanes in parallel: one history read and one multiply per tap,
// then a 32-step restoring divide; the tap count is the window, one less for
// an even window in centered modes, 1 in pass-through. an item that releases
// no result sends the sequencer from evaluation back to idle and frees the input;
// the last frame releases up to 16.
// in centered modes results lag by half the window.
// the result register holds one item; while the receiver stalls a finished
// result waits there, the next result is computed and held back until free.
// reset clears the configuration to pass-through, size 1, and empties the
// sequence; history contents are undefined until written.
`default_nettype none
module motion_curve_smoother (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// angle_x, angle_y, angle_z, move_x, move_y, move_z
	input  wire        [mcs_pkg::FRAME_BITS-1:0] s_axis_tdata,
	input  wire                                  s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// smooth_angle_x, smooth_angle_y, smooth_angle_z, smooth_move_x, smooth_move_y,
	// smooth_move_z
	output logic       [mcs_pkg::FRAME_BITS-1:0] m_axis_tdata,
	output logic                                 m_axis_tlast,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire                                  cfg_index,
	input  wire        [4:0]                     cfg_data
);

	localparam int SB = mcs_pkg::SAMPLE_BITS;
	localparam int AW = mcs_pkg::HIST_AW;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EVAL  = 8'b0000_0010,
		ST_TAP   = 8'b0000_0100,
		ST_DRAIN = 8'b0000_1000,
		ST_RND   = 8'b0001_0000,
		ST_LOAD  = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic [4:0] size_q;
	logic [AW-1:0] wr_pos_q;
	logic [6:0] pending_q;
	logic [15:0] emitted_q;
	logic last_q;
	logic [4:0] n_q;
	logic [AW-1:0] p_q;
	logic [AW-1:0] ahead_q;
	logic [AW-1:0] back_q;
	logic signed [6:0] k_q;
	logic signed [6:0] kmin_q;
	logic signed [6:0] kmax_q;
	logic eos_q;
	logic [mcs_pkg::TOT_W-1:0] total_q;
	logic vld_s1;
	logic [mcs_pkg::WGT_W-1:0] wgt_s1;
	logic [mcs_pkg::FRAME_BITS-1:0] rd_s1;
	logic dcnt_q;
	logic [4:0] cnt_q;
	logic [mcs_pkg::FRAME_BITS-1:0] hist [mcs_pkg::HIST_DEPTH];

	logic [4:0] s_eff;
	logic [3:0] h;
	logic centered;
	logic [6:0] keep;
	logic emit;
	logic signed [6:0] kmin;
	logic signed [6:0] kmax;
	logic [mcs_pkg::TOT_W-1:0] total;
	logic [9:0] s_prod;
	logic [6:0] ahead_w;
	logic [AW-1:0] back_lim;
	logic [4:0] j;
	logic [4:0] jm;
	logic [mcs_pkg::BINOM_AW-1:0] tri_base;
	logic [mcs_pkg::BINOM_AW-1:0] bidx;
	logic [mcs_pkg::WGT_W-1:0] weight;
	logic inrange;
	logic [AW-1:0] rd_addr;
	logic in_acc;
	logic out_free;
	logic out_load;
	mcs_pkg::lane_ctrl_t ctrl;
	logic signed [SB-1:0] lane_res [mcs_pkg::CHANNELS];

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mcs_pkg::MODE_PASS;
			size_q <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				mcs_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				mcs_pkg::REG_SIZE: size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// window shape for the current configuration
	always_comb begin
		s_eff = (size_q == 5'd0) ? 5'd1 : size_q;
		h = 4'((s_eff - 5'd1) >> 1);
		centered = (mode_q == mcs_pkg::MODE_AVG) || (mode_q == mcs_pkg::MODE_BINOM);
		keep = (last_q || !centered) ? 7'd0 : 7'(h);
		emit = (pending_q > keep) && (n_q < 5'(mcs_pkg::MAX_RESULTS));
		s_prod = 10'(s_eff) * (10'(s_eff) + 10'd1);
		case (mode_q)
			mcs_pkg::MODE_AVG: begin
				kmin = -7'(h);
				kmax = 7'(h);
				total = mcs_pkg::TOT_W'({h, 1'b1});
			end
			mcs_pkg::MODE_WGT: begin
				kmin = 7'(1) - 7'(s_eff);
				kmax = 7'd0;
				total = mcs_pkg::TOT_W'(s_prod >> 1);
			end
			mcs_pkg::MODE_BINOM: begin
				kmin = -7'(h);
				kmax = 7'(h);
				total = mcs_pkg::TOT_W'(1) << {h, 1'b0};
			end
			default: begin
				kmin = 7'd0;
				kmax = 7'd0;
				total = mcs_pkg::TOT_W'(1);
			end
		endcase
		ahead_w = pending_q - 7'd1;
		back_lim = AW'(mcs_pkg::HIST_DEPTH - 1) - ahead_w[AW-1:0];
	end

	// tap weight and history address
	always_comb begin
		j = 5'(k_q - kmin_q);
		jm = (j <= 5'(h)) ? j : 5'({h, 1'b0} - j);
		tri_base = mcs_pkg::BINOM_AW'((8'(h) * (8'(h) + 8'd1)) >> 1);
		bidx = tri_base + mcs_pkg::BINOM_AW'(jm);
		case (mode_q)
			mcs_pkg::MODE_WGT: weight = mcs_pkg::WGT_W'(j) + mcs_pkg::WGT_W'(1);
			mcs_pkg::MODE_BINOM: weight = mcs_pkg::BINOM[bidx];
			default: weight = mcs_pkg::WGT_W'(1);
		endcase
		inrange = (k_q < 0 && 7'(-k_q) <= 7'(back_q))
			|| (k_q > 0 && k_q <= $signed(7'(ahead_q)));
		rd_addr = inrange ? p_q + AW'(k_q) : p_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hist[wr_pos_q] <= s_axis_tdata ^ {mcs_pkg::CHANNELS{mcs_pkg::SIGN_BIT}};
		end
		if (state_q == ST_TAP) begin
			rd_s1 <= hist[rd_addr];
			wgt_s1 <= weight;
		end
	end

	assign out_load = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wr_pos_q <= '0;
			pending_q <= '0;
			emitted_q <= '0;
			last_q <= 1'b0;
			n_q <= '0;
			vld_s1 <= 1'b0;
			dcnt_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			vld_s1 <= (state_q == ST_TAP);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wr_pos_q <= wr_pos_q + AW'(1);
						pending_q <= pending_q + 7'd1;
						last_q <= s_axis_tlast;
						n_q <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (emit) begin
						state_q <= ST_TAP;
					end else begin
						if (last_q) begin
							pending_q <= '0;
							emitted_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TAP: begin
					if (k_q == kmax_q) begin
						dcnt_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					dcnt_q <= 1'b1;
					if (dcnt_q) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: state_q <= ST_LOAD;
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SB - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						pending_q <= pending_q - 7'd1;
						if (emitted_q != 16'hFFFF) begin
							emitted_q <= emitted_q + 16'd1;
						end
						n_q <= n_q + 5'd1;
						state_q <= ST_EVAL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			p_q <= wr_pos_q - pending_q[AW-1:0];
			ahead_q <= ahead_w[AW-1:0];
			back_q <= (emitted_q < 16'(back_lim)) ? emitted_q[AW-1:0] : back_lim;
			k_q <= kmin;
			kmin_q <= kmin;
			kmax_q <= kmax;
			total_q <= total;
			eos_q <= last_q && (pending_q == 7'd1);
		end else if (state_q == ST_TAP) begin
			k_q <= k_q + 7'sd1;
		end
	end

	always_comb begin
		ctrl.clr = (state_q == ST_EVAL) && emit;
		ctrl.vld_s1 = vld_s1;
		ctrl.rnd = (state_q == ST_RND);
		ctrl.load = (state_q == ST_LOAD);
		ctrl.step = (state_q == ST_DIV);
	end

	for (genvar g = 0; g < mcs_pkg::CHANNELS; g++) begin : g_lane
		mcs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.smp_s1 (rd_s1[g*SB +: SB]),
			.wgt_s1 (wgt_s1),
			.total  (total_q),
			.result (lane_res[g])
		);
	end

	mcs_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (out_load),
		.lane_res      (lane_res),
		.eos           (eos_q),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

FILE: rtl/mcs_lane.sv
// one channel lane: tap multiply-accumulate, rounding and restoring divide
`default_nettype none
module mcs_lane (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire        mcs_pkg::lane_ctrl_t        ctrl,
	input  wire        [mcs_pkg::SAMPLE_BITS-1:0]  smp_s1,
	input  wire        [mcs_pkg::WGT_W-1:0]        wgt_s1,
	input  wire        [mcs_pkg::TOT_W-1:0]        total,
	output logic signed [mcs_pkg::SAMPLE_BITS-1:0] result
);

	localparam int PROD_W = mcs_pkg::SAMPLE_BITS + mcs_pkg::WGT_W;
	localparam int SB = mcs_pkg::SAMPLE_BITS;

	logic [PROD_W-1:0] prod_s2;
	logic vld_s2;
	logic [mcs_pkg::ACC_W-1:0] acc_q;
	logic sat_q;
	logic [SB-1:0] rem_q;
	logic [SB-1:0] dq_q;
	logic [SB-1:0] rem_sh;
	logic ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctrl.vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.vld_s1) begin
			prod_s2 <= PROD_W'(smp_s1) * PROD_W'(wgt_s1);
		end
	end

	assign rem_sh = {rem_q[SB-2:0], dq_q[SB-1]};
	assign ge = rem_sh >= SB'(total);

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + mcs_pkg::ACC_W'(prod_s2);
		end else if (ctrl.rnd) begin
			acc_q <= acc_q + mcs_pkg::ACC_W'(total >> 1);
		end
		if (ctrl.load) begin
			sat_q <= acc_q >= {1'b0, total, {SB{1'b0}}};
			rem_q <= acc_q[mcs_pkg::ACC_W-1:SB];
			dq_q <= acc_q[SB-1:0];
		end else if (ctrl.step) begin
			rem_q <= ge ? rem_sh - SB'(total) : rem_sh;
			dq_q <= {dq_q[SB-2:0], ge};
		end
	end

	assign result = (sat_q ? {SB{1'b1}} : dq_q) ^ mcs_pkg::SIGN_BIT;

endmodule
`default_nettype wire

FILE: rtl/mcs_merge.sv
// output stage: gathers the lane results into one result item
`default_nettype none
module mcs_merge (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    load,
	input  wire signed [mcs_pkg::SAMPLE_BITS-1:0]  lane_res [mcs_pkg::CHANNELS],
	input  wire                                    eos,
	output logic                                   free,
	output logic                                   m_axis_tvalid,
	input  wire                                    m_axis_tready,
	// smooth_angle_x, smooth_angle_y, smooth_angle_z, smooth_move_x, smooth_move_y,
	// smooth_move_z
	output logic       [mcs_pkg::FRAME_BITS-1:0]   m_axis_tdata,
	output logic                                   m_axis_tlast
);

	localparam int SB = mcs_pkg::SAMPLE_BITS;

	assign free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int c = 0; c < mcs_pkg::CHANNELS; c++) begin
				m_axis_tdata[c*SB +: SB] <= lane_res[c];
			end
			m_axis_tlast <= eos;
		end
	end

endmodule
`default_nettype wire
